// ===== src/relay_motor_timed_move_controller_defines.svh =====
// Assertion macros for the relay motor timed move controller.
`ifndef RELAY_MOTOR_TIMED_MOVE_CONTROLLER_DEFINES_SVH
`define RELAY_MOTOR_TIMED_MOVE_CONTROLLER_DEFINES_SVH

// check on every rising clock edge outside reset
`define RMTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every rising clock edge, reset included
`define RMTC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/rmtc_pkg.sv =====
// Package: types, codes and word layouts of the relay motor timed move controller.
package rmtc_pkg;

   localparam int DEBOUNCE_TICKS_DEFAULT = 5;

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_FWD  = 2'd1,
      OP_REV  = 2'd2,
      OP_STOP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CAUSE_USER    = 2'd0,
      CAUSE_LIMIT   = 2'd1,
      CAUSE_TIMEOUT = 2'd2
   } cause_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] timeout_ms;
      logic [31:0] now_ms;
      logic        limit_level;
   } req_type;

   typedef struct packed {
      logic      forward_relay;
      logic      reverse_relay;
      logic      is_moving;
      cause_type stop_cause;
      logic      limit_stable;
   } rsp_type;

endpackage

// ===== src/rmtc_core.sv =====
// Motor state registers and the single-pass update for one command or tick.
module rmtc_core
   import rmtc_pkg::*;
#(
   parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type rsp
);

   localparam int CNT_W = $clog2(DEBOUNCE_TICKS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEBOUNCE_TICKS);

   logic             moving_ff, moving_in;
   logic             fwd_ff, fwd_in;
   logic             rev_ff, rev_in;
   logic [31:0]      start_ff, start_in;
   logic [31:0]      dur_ff, dur_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             stable_ff, stable_in;
   cause_type        cause_ff, cause_in;

   logic             raw;
   logic [CNT_W-1:0] cnt_inc;
   logic [31:0]      elapsed;

   always_comb begin
      moving_in = moving_ff;
      fwd_in    = fwd_ff;
      rev_in    = rev_ff;
      start_in  = start_ff;
      dur_in    = dur_ff;
      cnt_in    = cnt_ff;
      stable_in = stable_ff;
      cause_in  = cause_ff;
      raw       = ~req.limit_level;
      cnt_inc   = cnt_ff + CNT_W'(1);
      elapsed   = req.now_ms - start_ff;
      unique case (req.operation)
         OP_FWD, OP_REV: begin
            fwd_in    = (req.operation == OP_FWD);
            rev_in    = (req.operation == OP_REV);
            moving_in = 1'b1;
            start_in  = req.now_ms;
            dur_in    = req.timeout_ms;
            cnt_in    = '0;
         end
         OP_STOP: begin
            fwd_in    = 1'b1;
            rev_in    = 1'b1;
            moving_in = 1'b0;
            cause_in  = CAUSE_USER;
         end
         default: begin
            if (moving_ff) begin
               if (raw == stable_ff) begin
                  cnt_in = '0;
               end else if (cnt_inc >= CNT_MAX) begin
                  stable_in = raw;
                  cnt_in    = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
               if ((elapsed >= dur_ff) || stable_in) begin
                  fwd_in    = 1'b1;
                  rev_in    = 1'b1;
                  moving_in = 1'b0;
                  cause_in  = stable_in ? CAUSE_LIMIT : CAUSE_TIMEOUT;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff <= 1'b0;
         fwd_ff    <= 1'b1;
         rev_ff    <= 1'b1;
         start_ff  <= '0;
         dur_ff    <= '0;
         cnt_ff    <= '0;
         stable_ff <= 1'b0;
         cause_ff  <= CAUSE_USER;
      end else if (step) begin
         moving_ff <= moving_in;
         fwd_ff    <= fwd_in;
         rev_ff    <= rev_in;
         start_ff  <= start_in;
         dur_ff    <= dur_in;
         cnt_ff    <= cnt_in;
         stable_ff <= stable_in;
         cause_ff  <= cause_in;
      end
   end

   assign rsp.forward_relay = fwd_in;
   assign rsp.reverse_relay = rev_in;
   assign rsp.is_moving     = moving_in;
   assign rsp.stop_cause    = cause_in;
   assign rsp.limit_stable  = stable_in;

endmodule

// ===== src/relay_motor_timed_move_controller.sv =====
// Top level: input word register, motor update core and result word register.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser operation, tdata timeout/now/limit
//   rsp      out  rsp_tvalid/tready    tdata relays, moving, cause, limit
//
// One word per cycle sustained while rsp is not stalled; rsp valid is set as the
// accepted word moves from the input register to the result register. The state
// update happens in that move, so throughput is set by that register-to-register pass.
// Reset clears both valid flags and the motor state; nothing else needs clearing.
// A stalled rsp holds its word; req is ready while the input register is free
// or drains in the same cycle.
module relay_motor_timed_move_controller
   import rmtc_pkg::*;
#(
   parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] timeout_ms, [63:32] now_ms, [64] limit_level, [71:65] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] forward_relay, [1] reverse_relay, [2] is_moving, [4:3] stop_cause,
   // [5] limit_stable, [7:6] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type core_rsp;
   logic    advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_in.operation   = op_type'(req_tuser[1:0]);
      in_in.timeout_ms  = req_tdata[31:0];
      in_in.now_ms      = req_tdata[63:32];
      in_in.limit_level = req_tdata[64];
      in_valid_in       = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      out_valid_in      = advance || (out_valid_ff && !rsp_tready);
   end

   rmtc_core #(
      .DEBOUNCE_TICKS(DEBOUNCE_TICKS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step (advance),
      .req  (in_ff),
      .rsp  (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff <= in_in;
      end
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.limit_stable, out_ff.stop_cause, out_ff.is_moving,
                        out_ff.reverse_relay, out_ff.forward_relay};

endmodule

// ===== src/rmtc_checker.sv =====
// Port-level checks for the relay motor timed move controller, bound to the top level.
`include "relay_motor_timed_move_controller_defines.svh"

module rmtc_checker
   import rmtc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `RMTC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")
   `RMTC_ASSERT(a_moving_one_relay, rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[0] != rsp_tdata[1], "moving with both relays equal")
   `RMTC_ASSERT(a_idle_relays_high, rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[0] && rsp_tdata[1], "idle motor with a relay low")
   `RMTC_ASSERT(a_cause_code, rsp_tvalid |-> rsp_tdata[4:3] != 2'd3 && rsp_tdata[7:6] == 2'd0, "bad stop cause or padding")
   `RMTC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind relay_motor_timed_move_controller rmtc_checker u_rmtc_checker (.*);
